/* src/cgns_pkg.sv */
// Shared types, register codes and compass weights for the compass edge stream.
package cgns_pkg;

	// Build defaults for the top level parameters
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;

	// Configuration port
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 12;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;
	localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
	localparam int MIN_SIZE = 3;

	// Row counters run up to three rows past the last frame row while flushing
	localparam int ROW_BITS = 13;

	typedef struct packed {
		logic [7:0] pixel;
		logic       dummy;
	} in_item_t;

	typedef struct packed {
		logic [9:0]  edge_value;
		logic [2:0]  direction;
		logic [9:0]  col;
		logic [11:0] row;
		logic        last;
	} out_item_t;

	// Element r*3+c weights pixel (y+r-1, x+c-1)
	localparam logic signed [2:0] COMPASS [8][9] = '{
		'{-3'sd1,  3'sd0,  3'sd1, -3'sd2,  3'sd0,  3'sd2, -3'sd1,  3'sd0,  3'sd1},
		'{ 3'sd0,  3'sd1,  3'sd2, -3'sd1,  3'sd0,  3'sd1, -3'sd2, -3'sd1,  3'sd0},
		'{ 3'sd1,  3'sd2,  3'sd1,  3'sd0,  3'sd0,  3'sd0, -3'sd1, -3'sd2, -3'sd1},
		'{ 3'sd2,  3'sd1,  3'sd0,  3'sd1,  3'sd0, -3'sd1,  3'sd0, -3'sd1, -3'sd2},
		'{ 3'sd1,  3'sd0, -3'sd1,  3'sd2,  3'sd0, -3'sd2,  3'sd1,  3'sd0, -3'sd1},
		'{ 3'sd0, -3'sd1, -3'sd2,  3'sd1,  3'sd0, -3'sd1,  3'sd2,  3'sd1,  3'sd0},
		'{-3'sd1, -3'sd2, -3'sd1,  3'sd0,  3'sd0,  3'sd0,  3'sd1,  3'sd2,  3'sd1},
		'{-3'sd2, -3'sd1,  3'sd0, -3'sd1,  3'sd0,  3'sd1,  3'sd0,  3'sd1,  3'sd2}
	};

	localparam logic [2:0] DIR_NONE = 3'd2;

endpackage

/* src/compass_gradient_nms_stream.sv */
// Top level: streaming compass edge detector with non-maximum suppression.
//
// Pixels enter in raster order on in_valid/in_ready; results leave on
// out_valid/out_ready, one per pixel, in raster order. A pixel's result
// comes with the input 2*W+2 pixel slots later (W = frame width) and shows on
// out_valid after that input passes the pipeline; after the last pixel of a
// frame, 2*W+2 more inputs (dummy or not) push out the tail, and the input
// after that starts the next frame. A dummy input inside the frame is taken
// and dropped. Throughput is one item per cycle while the skid is empty,
// set by the read-modify-write of the two line memories (one pixel store,
// one gradient store, one entry per column). frame_width and frame_height
// are written on cfg_we/cfg_index/cfg_data and latched at the first input
// of each frame; out-of-range sizes are clamped. Reset clears the slot
// counters, the pipeline and the output stage; the line memories are not
// cleared, since every entry is written before it is used. When the
// receiver stalls, one result parks in a skid register and in_ready drops
// the next cycle; the whole pipeline holds until the skid drains.
module compass_gradient_nms_stream import cgns_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  in_item_t                  in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output out_item_t                 out_data,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PB = PIXEL_BITS;
	localparam int GW = PIXEL_BITS + 2;
	localparam int GE = GW + 3;
	localparam int RB = ROW_BITS;
	localparam int RST_W = (int'(FRAME_WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH :
		int'(FRAME_WIDTH_RST);

	typedef struct packed {
		logic          pwrite;
		logic [AW-1:0] px;
		logic          gtop;
		logic          gbot;
		logic          gleft;
		logic          gright;
		logic          gwrite;
		logic [AW-1:0] gx;
		logic          oon;
		logic [AW-1:0] ocol;
		logic [RB-1:0] orow;
		logic          inner;
		logic          last;
	} ctl_t;

	// Configuration and frame state
	logic [10:0]   width_q;
	logic [11:0]   height_q;
	logic [WW-1:0] cur_w_q;
	logic [11:0]   cur_h_q;
	logic [AW-1:0] s_col_q;
	logic [RB-1:0] s_row_q;

	// Pipeline
	logic          en;
	logic          v_s1, v_s2, v_s3, v_s4;
	ctl_t          ctl_in, ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [PB-1:0] pix_in, pix_s1;
	logic [9*PB-1:0] win_s2;
	logic [GW-1:0] mag_s4;
	logic [2:0]    dir_s4;

	// Line memories
	logic [2*PB-1:0] pix_mem [MAX_WIDTH];
	logic [2*PB-1:0] pm_rd_q;
	logic [2*GE-1:0] grad_mem [MAX_WIDTH];
	logic [2*GE-1:0] gm_rd_q;

	// Sliding columns: index 0 top row, 2 bottom row
	logic [PB-1:0] pcol [3];
	logic [PB-1:0] pc0_q [3];
	logic [PB-1:0] pc1_q [3];
	logic [GE-1:0] gcol [3];
	logic [GE-1:0] gc0_q [3];
	logic [GE-1:0] gc1_q [3];

	// Output stage
	logic      out_valid_q, skid_valid_q;
	out_item_t out_q, skid_q, res;
	logic      push;

	// Slot decode
	logic [12:0]   w_reg13, w_clamp13;
	logic [WW-1:0] w_clamp, w_eff;
	logic [11:0]   h_clamp, h_eff;
	logic [AW-1:0] wm1;
	logic [RB-1:0] h13, hm1, hm2;
	logic          at_start, flush, slot, accept;
	logic          g_on, o_on;
	logic [AW-1:0] gc, oc;
	logic [RB-1:0] gr, orw;
	logic          last_o;

	// Clamp the written sizes
	always_comb begin
		w_reg13 = {2'b00, width_q};
		if (w_reg13 < 13'(MIN_SIZE)) begin
			w_clamp13 = 13'(MIN_SIZE);
		end else if (w_reg13 > 13'(MAX_WIDTH)) begin
			w_clamp13 = 13'(MAX_WIDTH);
		end else begin
			w_clamp13 = w_reg13;
		end
		w_clamp = w_clamp13[WW-1:0];
		h_clamp = (height_q < 12'(MIN_SIZE)) ? 12'(MIN_SIZE) : height_q;
	end

	// Decode the current slot: its gradient center and its output pixel
	always_comb begin
		at_start = (s_col_q == '0) && (s_row_q == '0);
		w_eff    = at_start ? w_clamp : cur_w_q;
		h_eff    = at_start ? h_clamp : cur_h_q;
		wm1      = AW'(w_eff - 1'b1);
		h13      = {1'b0, h_eff};
		hm1      = h13 - 1'b1;
		hm2      = h13 - RB'(2);
		flush    = s_row_q >= h13;
		accept   = in_valid && in_ready;
		slot     = accept && (flush || !in_data.dummy);

		g_on = (s_row_q > RB'(1)) || ((s_row_q == RB'(1)) && (s_col_q != '0));
		o_on = (s_row_q > RB'(2)) || ((s_row_q == RB'(2)) && (s_col_q >= AW'(2)));
		if (s_col_q != '0) begin
			gc = s_col_q - 1'b1;
			gr = s_row_q - 1'b1;
		end else begin
			gc = wm1;
			gr = s_row_q - RB'(2);
		end
		if (s_col_q >= AW'(2)) begin
			oc  = s_col_q - AW'(2);
			orw = s_row_q - RB'(2);
		end else begin
			oc  = s_col_q + wm1 - 1'b1;
			orw = s_row_q - RB'(3);
		end
		last_o = o_on && (orw == hm1) && (oc == wm1);

		ctl_in.pwrite = !flush;
		ctl_in.px     = s_col_q;
		ctl_in.gtop   = (gr == '0);
		ctl_in.gbot   = (gr >= hm1);
		ctl_in.gleft  = (gc == '0);
		ctl_in.gright = (gc == wm1);
		ctl_in.gwrite = g_on && (gr < h13);
		ctl_in.gx     = gc;
		ctl_in.oon    = o_on;
		ctl_in.ocol   = oc;
		ctl_in.orow   = orw;
		ctl_in.inner  = (orw != '0) && (oc != '0) && (orw <= hm2) && (oc <= wm1 - 1'b1);
		ctl_in.last   = last_o;

		pix_in = PB'({16'b0, in_data.pixel});
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  width_q  <= cfg_data[10:0];
				CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latch the frame size and advance the slot position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_w_q <= WW'(RST_W);
			cur_h_q <= FRAME_HEIGHT_RST;
			s_col_q <= '0;
			s_row_q <= '0;
		end else begin
			if (accept && at_start) begin
				cur_w_q <= w_clamp;
				cur_h_q <= h_clamp;
			end
			if (slot) begin
				if (last_o) begin
					s_col_q <= '0;
					s_row_q <= '0;
				end else if (s_col_q == wm1) begin
					s_col_q <= '0;
					s_row_q <= s_row_q + 1'b1;
				end else begin
					s_col_q <= s_col_q + 1'b1;
				end
			end
		end
	end

	// Advance the pipeline unless a result is parked in the skid register
	assign en       = !skid_valid_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= slot;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_in;
			pix_s1 <= pix_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// Pixel line store: read on entry to stage 1, write back as it leaves
	always_ff @(posedge clk) begin
		if (en) begin
			pm_rd_q <= pix_mem[s_col_q];
			if (v_s1 && ctl_s1.pwrite) begin
				pix_mem[ctl_s1.px] <= {pix_s1, pm_rd_q[2*PB-1:PB]};
			end
		end
	end

	assign pcol[0] = pm_rd_q[PB-1:0];
	assign pcol[1] = pm_rd_q[2*PB-1:PB];
	assign pcol[2] = pix_s1;

	// Shift the pixel columns and register the masked 3x3 window
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s1) begin
				pc0_q <= pcol;
				pc1_q <= pc0_q;
			end
			for (int r = 0; r < 3; r++) begin
				win_s2[(r*3+0)*PB +: PB] <= (ctl_s1.gleft || (r == 0 && ctl_s1.gtop) ||
					(r == 2 && ctl_s1.gbot)) ? '0 : pc1_q[r];
				win_s2[(r*3+1)*PB +: PB] <= ((r == 0 && ctl_s1.gtop) ||
					(r == 2 && ctl_s1.gbot)) ? '0 : pc0_q[r];
				win_s2[(r*3+2)*PB +: PB] <= (ctl_s1.gright || (r == 0 && ctl_s1.gtop) ||
					(r == 2 && ctl_s1.gbot)) ? '0 : pcol[r];
			end
		end
	end

	cgns_compass #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_compass (
		.clk (clk),
		.en  (en),
		.win (win_s2),
		.mag (mag_s4),
		.dir (dir_s4)
	);

	// Gradient line store: read on entry to stage 4, write back as it leaves
	always_ff @(posedge clk) begin
		if (en) begin
			gm_rd_q <= grad_mem[ctl_s3.gx];
			if (v_s4 && ctl_s4.gwrite) begin
				grad_mem[ctl_s4.gx] <= {mag_s4, dir_s4, gm_rd_q[2*GE-1:GE]};
			end
		end
	end

	assign gcol[0] = gm_rd_q[GE-1:0];
	assign gcol[1] = gm_rd_q[2*GE-1:GE];
	assign gcol[2] = {mag_s4, dir_s4};

	always_ff @(posedge clk) begin
		if (en && v_s4) begin
			gc0_q <= gcol;
			gc1_q <= gc0_q;
		end
	end

	// Suppress non-maxima along the center's direction pair
	logic [GW-1:0]    g_c, g_a, g_b, g_val;
	logic [GW+9:0]    val_ext;
	logic [AW+9:0]    col_ext;
	always_comb begin
		g_c = gc0_q[1][GE-1:3];
		case (gc0_q[1][1:0])
			2'd0: begin
				g_a = gc1_q[1][GE-1:3];
				g_b = gcol[1][GE-1:3];
			end
			2'd1: begin
				g_a = gcol[0][GE-1:3];
				g_b = gc1_q[2][GE-1:3];
			end
			2'd2: begin
				g_a = gc0_q[0][GE-1:3];
				g_b = gc0_q[2][GE-1:3];
			end
			default: begin
				g_a = gc1_q[0][GE-1:3];
				g_b = gcol[2][GE-1:3];
			end
		endcase
		g_val = (ctl_s4.inner && g_c > g_a && g_c > g_b) ? g_c : '0;
		val_ext = {10'b0, g_val};
		col_ext = {10'b0, ctl_s4.ocol};
		res.edge_value = val_ext[9:0];
		res.direction  = gc0_q[1][2:0];
		res.col        = col_ext[9:0];
		res.row        = ctl_s4.orow[11:0];
		res.last       = ctl_s4.last;
		push = en && v_s4 && ctl_s4.oon;
	end

	// Output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A parked result always sits behind a held one
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds an item while the output is empty");

	// The top border row never carries an edge
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.edge_value != '0) |-> (out_data.row != '0))
		else $error("edge reported on the top border row");

	// Slot column stays inside the latched frame width
	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(s_col_q != '0) |-> (WW'(s_col_q) < cur_w_q))
		else $error("slot column beyond frame width");

	// Nothing enters while the skid is full
	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> ($stable(s_col_q) && $stable(s_row_q)))
		else $error("slot advanced while the output was blocked");

endmodule

/* src/cgns_compass.sv */
// Eight compass mask responses and first-index maximum, two register stages.
module cgns_compass import cgns_pkg::*; #(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [9*PIXEL_BITS-1:0]   win,
	output logic [PIXEL_BITS+1:0]     mag,
	output logic [2:0]                dir
);

	localparam int PB = PIXEL_BITS;
	localparam int RW = PIXEL_BITS + 4;
	localparam int GW = PIXEL_BITS + 2;

	logic signed [RW-1:0] resp [8];
	logic signed [RW-1:0] resp_s3 [8];
	logic signed [RW-1:0] v1 [4];
	logic [2:0]           i1 [4];
	logic signed [RW-1:0] v2 [2];
	logic [2:0]           i2 [2];
	logic signed [RW-1:0] v3;
	logic [2:0]           i3;

	// Weighted sums, one per mask
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			resp[k] = '0;
			for (int e = 0; e < 9; e++) begin
				resp[k] = resp[k] +
					$signed({{(RW-PB){1'b0}}, win[e*PB +: PB]}) *
					$signed({{(RW-3){COMPASS[k][e][2]}}, COMPASS[k][e]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			resp_s3 <= resp;
		end
	end

	// Reduce with a tree that keeps the lower index on ties
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (resp_s3[2*i] >= resp_s3[2*i+1]) begin
				v1[i] = resp_s3[2*i];
				i1[i] = 3'(2*i);
			end else begin
				v1[i] = resp_s3[2*i+1];
				i1[i] = 3'(2*i+1);
			end
		end
		for (int i = 0; i < 2; i++) begin
			if (v1[2*i] >= v1[2*i+1]) begin
				v2[i] = v1[2*i];
				i2[i] = i1[2*i];
			end else begin
				v2[i] = v1[2*i+1];
				i2[i] = i1[2*i+1];
			end
		end
		if (v2[0] >= v2[1]) begin
			v3 = v2[0];
			i3 = i2[0];
		end else begin
			v3 = v2[1];
			i3 = i2[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v3 > 0) begin
				mag <= v3[GW-1:0];
				dir <= i3;
			end else begin
				mag <= '0;
				dir <= DIR_NONE;
			end
		end
	end

endmodule

/* dv/compass_gradient_nms_stream_tb.sv */
// Self-checking testbench for the compass edge detector with non-maximum suppression.
module compass_gradient_nms_stream_tb;
	import cgns_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_MAX = MAX_WIDTH_DEF;

	// Tracks the raster position and line stores, predicts each edge item
	class compass_edge_tracker;
		int unsigned reg_w, reg_h, cur_w, cur_h, in_col, in_row;
		int unsigned pix_line [3][LINE_MAX];
		int unsigned grad_mag [3][LINE_MAX];
		bit [2:0]    grad_dir [3][LINE_MAX];
		out_item_t   pending_edges [$];
		int          n_errors;

		function new();
			reg_w = FRAME_WIDTH_RST;
			reg_h = FRAME_HEIGHT_RST;
			cur_w = reg_w;
			cur_h = reg_h;
			in_col = 0;
			in_row = 0;
			n_errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
			if (idx == CFG_FRAME_WIDTH)
				reg_w = val[10:0];
			else
				reg_h = val[11:0];
		endfunction

		function int unsigned pix_at(longint y, longint x);
			if (y < 0 || x < 0 || y >= cur_h || x >= cur_w)
				return 0;
			return pix_line[y % 3][x];
		endfunction

		// Apply all eight masks, keep the first strongest positive response
		function void grade(longint y, longint x);
			int win [9];
			int best, acc;
			bit [2:0] dir;
			best = 0;
			dir = DIR_NONE;
			for (int e = 0; e < 9; e++)
				win[e] = pix_at(y + e / 3 - 1, x + e % 3 - 1);
			for (int k = 0; k < 8; k++) begin
				acc = 0;
				for (int e = 0; e < 9; e++)
					acc += int'(COMPASS[k][e]) * win[e];
				if (acc > best) begin
					best = acc;
					dir = 3'(k);
				end
			end
			grad_mag[y % 3][x] = best;
			grad_dir[y % 3][x] = dir;
		endfunction

		function void take_pixel(in_item_t it);
			longint w, total, s, g, o, oy, ox;
			int unsigned gc, a, b, val;
			bit [2:0] d;
			out_item_t r;
			if (in_row == 0 && in_col == 0) begin
				cur_w = reg_w < MIN_SIZE ? MIN_SIZE : (reg_w > LINE_MAX ? LINE_MAX : reg_w);
				cur_h = reg_h < MIN_SIZE ? MIN_SIZE : (reg_h > 4095 ? 4095 : reg_h);
			end
			w = cur_w;
			total = w * cur_h;
			s = longint'(in_row) * w + in_col;
			if (s < total) begin
				// drop a dummy inside the frame
				if (it.dummy)
					return;
				pix_line[in_row % 3][in_col] = it.pixel;
			end
			if (s >= w + 1) begin
				g = s - w - 1;
				if (g < total)
					grade(g / w, g % w);
			end
			if (s >= 2 * w + 2) begin
				o = s - 2 * w - 2;
				oy = o / w;
				ox = o % w;
				gc = grad_mag[oy % 3][ox];
				d = grad_dir[oy % 3][ox];
				val = 0;
				if (oy >= 1 && ox >= 1 && oy <= cur_h - 2 && ox <= w - 2) begin
					case (d[1:0])
						2'd0: begin a = grad_mag[oy % 3][ox - 1]; b = grad_mag[oy % 3][ox + 1]; end
						2'd1: begin
							a = grad_mag[(oy - 1) % 3][ox + 1];
							b = grad_mag[(oy + 1) % 3][ox - 1];
						end
						2'd2: begin a = grad_mag[(oy - 1) % 3][ox]; b = grad_mag[(oy + 1) % 3][ox]; end
						default: begin
							a = grad_mag[(oy - 1) % 3][ox - 1];
							b = grad_mag[(oy + 1) % 3][ox + 1];
						end
					endcase
					if (gc > a && gc > b)
						val = gc;
				end
				r.edge_value = val[9:0];
				r.direction = d;
				r.col = ox[9:0];
				r.row = oy[11:0];
				r.last = (o == total - 1);
				pending_edges.push_back(r);
				if (o == total - 1) begin
					in_col = 0;
					in_row = 0;
					return;
				end
			end
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		endfunction

		function void check_edge(out_item_t got);
			out_item_t exp_e;
			if (pending_edges.size() == 0) begin
				$error("edge item with nothing pending: %p", got);
				n_errors++;
				return;
			end
			exp_e = pending_edges.pop_front();
			if (got.edge_value !== exp_e.edge_value) begin
				$error("edge_value: expected %0d, actual %0d", exp_e.edge_value, got.edge_value);
				n_errors++;
			end
			if (got.direction !== exp_e.direction) begin
				$error("direction: expected %0d, actual %0d", exp_e.direction, got.direction);
				n_errors++;
			end
			if (got.col !== exp_e.col) begin
				$error("col: expected %0d, actual %0d", exp_e.col, got.col);
				n_errors++;
			end
			if (got.row !== exp_e.row) begin
				$error("row: expected %0d, actual %0d", exp_e.row, got.row);
				n_errors++;
			end
			if (got.last !== exp_e.last) begin
				$error("last: expected %0d, actual %0d", exp_e.last, got.last);
				n_errors++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	in_item_t                 in_data;
	logic                     out_valid;
	logic                     out_ready;
	out_item_t                out_data;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	compass_edge_tracker tracker;
	bit calm;
	int items_sent;

	compass_gradient_nms_stream u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Draw an idle count; calm phases never idle
	function automatic int draw_idle();
		if (calm || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	// Hold one item until the block takes it, then idle for a drawn count
	task automatic push_item(logic [7:0] px, logic dm);
		int gap;
		in_item_t it;
		it.pixel = px;
		it.dummy = dm;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.take_pixel(it);
		items_sent++;
		gap = draw_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		tracker.set_reg(idx, val);
		cfg_we <= 1'b0;
	endtask

	// Wait for every pending edge item, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_edges.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_size(int w, int h);
		drain();
		write_reg(CFG_FRAME_WIDTH, CFG_DATA_BITS'(w));
		write_reg(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
		calm = ($urandom_range(0, 3) == 0);
	endtask

	function automatic logic [7:0] pick_pixel(int kind, int i);
		case (kind)
			0: return 8'($urandom_range(0, 255));
			1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			2: return 8'(i * 17 + $urandom_range(0, 3));
			default: return 8'(128 + $urandom_range(0, 40) - 20);
		endcase
	endfunction

	// Send one frame of pixels with stray dummies, then the flush inputs
	task automatic send_frame(int dummy_pct);
		int w, h, kind;
		w = tracker.reg_w < MIN_SIZE ? MIN_SIZE :
			(tracker.reg_w > LINE_MAX ? LINE_MAX : tracker.reg_w);
		h = tracker.reg_h < MIN_SIZE ? MIN_SIZE : (tracker.reg_h > 4095 ? 4095 : tracker.reg_h);
		kind = $urandom_range(0, 3);
		for (int i = 0; i < w * h; i++) begin
			if ($urandom_range(0, 99) < dummy_pct)
				push_item(8'($urandom_range(0, 255)), 1'b1);
			push_item(pick_pixel(kind, i), 1'b0);
		end
		for (int i = 0; i < 2 * w + 2; i++)
			push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// Take edge items, stalling a drawn count after each
	initial begin
		int n;
		out_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				tracker.check_edge(out_data);
				n = draw_idle();
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		logic [7:0] checker_px [9];
		bit paused;
		tracker = new();
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		items_sent = 0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame: checkerboard of extremes, then flat white, each followed by its flush inputs
		checker_px = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
		set_size(3, 3);
		push_item(8'h5A, 1'b1);
		for (int i = 0; i < 9; i++)
			push_item(checker_px[i], 1'b0);
		for (int i = 0; i < 8; i++)
			push_item(8'hA5, i[0]);
		for (int i = 0; i < 9; i++)
			push_item(8'hFF, 1'b0);
		for (int i = 0; i < 8; i++)
			push_item(8'h00, 1'b1);

		// Out-of-range sizes clamp up
		set_size(0, 0);
		send_frame(20);
		set_size(2, 2);
		send_frame(5);

		// One frame with wider lines
		set_size(48, 3);
		send_frame(1);

		// Random small frames, mostly several per size
		while (items_sent < 1100) begin
			set_size($urandom_range(3, 20), $urandom_range(3, 12));
			repeat ($urandom_range(1, 3)) begin
				send_frame($urandom_range(0, 15));
				if (!paused && $urandom_range(0, 2) == 0) begin
					// let everything drain with the sender held mid-stream
					drain();
					paused = 1'b1;
				end
			end
		end

		drain();
		if (tracker.pending_edges.size() != 0)
			tracker.n_errors++;
		if (tracker.n_errors == 0)
			$display("compass_gradient_nms_stream_tb: done, clean");
		else
			$display("compass_gradient_nms_stream_tb: done, errors");
		$finish;
	end

	initial begin
		#40ms;
		$display("compass_gradient_nms_stream_tb: done, errors");
		$finish;
	end

endmodule
